FILE: hw/rtl/bipm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bipm_pkg
// Shared codes, widths and control structs of the partition mapper.
// ----------------------------------------------------------------------------
package bipm_pkg;

  localparam int DEF_MAX_UNITS = 64;
  localparam int DEF_ID_BITS   = 32;

  localparam int ACT_W      = 3;
  localparam int UNIT_W     = 7;
  localparam int ID_W       = 32;
  localparam int OWN_W      = 6;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [ACT_W-1:0] ACT_BUILD   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_TOP     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_WRITE   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_L2G     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_OWNER   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_COUNT   = 3'd5;
  localparam logic [ACT_W-1:0] ACT_LARGEST = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNUSED  = 3'd7;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNSUP = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNITS = 1'd1;

  localparam logic [1:0] RA_NONE = 2'd0;
  localparam logic [1:0] RA_UNIT = 2'd1;
  localparam logic [1:0] RA_CHK  = 2'd2;
  localparam logic [1:0] RA_IDX  = 2'd3;

  localparam logic [1:0] WR_NONE  = 2'd0;
  localparam logic [1:0] WR_BUILD = 2'd1;
  localparam logic [1:0] WR_TOP   = 2'd2;
  localparam logic [1:0] WR_UNIT  = 2'd3;

  localparam logic [2:0] IDX_HOLD  = 3'd0;
  localparam logic [2:0] IDX_CLR   = 3'd1;
  localparam logic [2:0] IDX_INC   = 3'd2;
  localparam logic [2:0] IDX_DEC   = 3'd3;
  localparam logic [2:0] IDX_GUESS = 3'd4;

  localparam logic [2:0] RES_ZERO = 3'd0;
  localparam logic [2:0] RES_L2G  = 3'd1;
  localparam logic [2:0] RES_CNT  = 3'd2;
  localparam logic [2:0] RES_OWN  = 3'd3;
  localparam logic [2:0] RES_BEST = 3'd4;

  localparam logic DIV_BUILD = 1'b0;
  localparam logic DIV_OWNER = 1'b1;

  typedef struct packed {
    logic              load;
    logic [1:0]        rd_sel;
    logic [1:0]        wr_sel;
    logic              tv_set;
    logic              tv_clr;
    logic              div_start;
    logic              div_sel;
    logic              prod_ld;
    logic [2:0]        idx_op;
    logic              acc_clr;
    logic              acc_add;
    logic              best_ld;
    logic              res_ld;
    logic [2:0]        res_sel;
    logic [STAT_W-1:0] res_st;
    logic              out_ld;
  } bipm_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             bad_p;
    logic             unsup;
    logic             tv;
    logic             unit_gt_p;
    logic             unit_ge_p;
    logic             g_ge_t1;
    logic             g_lt_t0;
    logic             idx_lt_pm1;
    logic             idx_gt_0;
    logic             idx_eq_p;
    logic             div_busy;
  } bipm_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/bipm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bipm_if
// Valid/ready channels of the partition mapper: request, response, config.
// ----------------------------------------------------------------------------
interface bipm_req_if import bipm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [UNIT_W-1:0] unit;
  logic [ID_W-1:0]   id_value;
  logic [ID_W-1:0]   offset_value;
  modport source (output valid, action, unit, id_value, offset_value, input ready);
  modport sink   (input valid, action, unit, id_value, offset_value, output ready);
endinterface

interface bipm_rsp_if import bipm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   result_value;
  logic [OWN_W-1:0]  owner_unit;
  logic [STAT_W-1:0] status;
  modport source (output valid, result_value, owner_unit, status, input ready);
  modport sink   (input valid, result_value, owner_unit, status, output ready);
endinterface

interface bipm_cfg_if import bipm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/bipm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bipm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bipm_div import bipm_pkg::*; #(
  parameter int DW = DEF_ID_BITS + UNIT_W,
  parameter int VW = DEF_ID_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quo,
  output logic [VW-1:0] rem
);
  localparam int CW = $clog2(DW + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem_r, quo_r[DW-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= VW'(trial - {1'b0, dvs_r});
      end else begin
        rem_r <= trial[VW-1:0];
      end
      quo_r <= {quo_r[DW-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

FILE: hw/rtl/bipm_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bipm_dp
// Datapath: config registers, offset table memory, divider, result registers.
// ----------------------------------------------------------------------------
module bipm_dp import bipm_pkg::*; #(
  parameter int MAX_UNITS = DEF_MAX_UNITS,
  parameter int ID_BITS   = DEF_ID_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bipm_cmd_t             cmd,
  output bipm_stat_t            stat,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [ACT_W-1:0]      in_action,
  input  logic [UNIT_W-1:0]     in_unit,
  input  logic [ID_W-1:0]       in_id_value,
  input  logic [ID_W-1:0]       in_offset_value,
  output logic [ID_W-1:0]       out_result_value,
  output logic [OWN_W-1:0]      out_owner_unit,
  output logic [STAT_W-1:0]     out_status
);
  localparam int AW = $clog2(MAX_UNITS + 1);
  localparam int DW = ID_BITS + UNIT_W;

  logic [CFG_DATA_W-1:0] tot_r;
  logic [UNIT_W-1:0]     cnt_r;
  logic [ACT_W-1:0]      act_r;
  logic [UNIT_W-1:0]     unit_r;
  logic [ID_BITS-1:0]    g_r;
  logic [ID_BITS-1:0]    off_r;
  logic [DW-1:0]         prod_r;
  logic [AW-1:0]         idx_r;
  logic [AW-1:0]         idx_nxt;
  logic [ID_BITS-1:0]    acc_r;
  logic signed [ID_BITS:0] best_r;
  logic                  tv_r;

  logic [ID_BITS-1:0] mem [0:MAX_UNITS];
  logic [MAX_UNITS:0] vld_r;
  logic [ID_BITS-1:0] rd0_r, rd1_r;
  logic               rv0_r, rv1_r;
  logic [ID_BITS-1:0] t0, t1;

  logic [ID_BITS-1:0] n;
  logic [AW-1:0]      ra0, ra1, wa;
  logic [ID_BITS-1:0] wd;
  logic               wr_en;
  logic               rd_en;

  logic               div_start;
  logic [DW-1:0]      div_dvd;
  logic [ID_BITS-1:0] div_dvs;
  logic               div_busy;
  logic [DW-1:0]      div_quo;
  logic [ID_BITS-1:0] div_rem;
  logic [DW-1:0]      pm1;
  logic [DW-1:0]      guess;

  logic [ID_BITS-1:0]      sum_l2g, dif_cnt, dif_own;
  logic signed [ID_BITS:0] d;
  logic                    incr;

  logic [ID_W-1:0]   res_val_r;
  logic [OWN_W-1:0]  res_own_r;
  logic [STAT_W-1:0] res_st_r;
  logic [ID_W-1:0]   out_val_r;
  logic [OWN_W-1:0]  out_own_r;
  logic [STAT_W-1:0] out_st_r;

  assign n  = ID_BITS'(tot_r);
  assign t0 = rv0_r ? rd0_r : '0;
  assign t1 = rv1_r ? rd1_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r <= '0;
      cnt_r <= UNIT_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TOTAL: tot_r <= cfg_data;
        CFG_UNITS: cnt_r <= UNIT_W'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      unit_r <= in_unit;
      g_r    <= ID_BITS'(in_id_value);
      off_r  <= ID_BITS'(in_offset_value);
    end
    if (cmd.prod_ld) begin
      prod_r <= DW'(g_r) * DW'(cnt_r);
    end
  end

  // table access
  always_comb begin
    ra0 = '0;
    ra1 = '0;
    case (cmd.rd_sel)
      RA_UNIT: begin
        ra0 = AW'(unit_r);
        ra1 = AW'(unit_r) + AW'(1);
      end
      RA_CHK: begin
        ra0 = '0;
        ra1 = AW'(cnt_r);
      end
      RA_IDX: begin
        ra0 = idx_r;
        ra1 = idx_r + AW'(1);
      end
      default: ;
    endcase
  end
  assign rd_en = cmd.rd_sel != RA_NONE;

  always_comb begin
    wa = '0;
    wd = '0;
    case (cmd.wr_sel)
      WR_BUILD: begin
        wa = idx_r;
        wd = stat.idx_eq_p ? n : acc_r;
      end
      WR_TOP: begin
        wa = AW'(cnt_r);
        wd = n;
      end
      WR_UNIT: begin
        wa = AW'(unit_r);
        wd = off_r;
      end
      default: ;
    endcase
  end
  assign wr_en = cmd.wr_sel != WR_NONE;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd0_r <= mem[ra0];
      rd1_r <= mem[ra1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rv0_r <= 1'b0;
      rv1_r <= 1'b0;
      tv_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wa] <= 1'b1;
      end
      if (rd_en) begin
        rv0_r <= vld_r[ra0];
        rv1_r <= vld_r[ra1];
      end
      if (cmd.tv_set) begin
        tv_r <= 1'b1;
      end else if (cmd.tv_clr) begin
        tv_r <= 1'b0;
      end
    end
  end

  // divider: n / p for the build, g*p / top for the owner guess
  assign div_start = cmd.div_start;
  assign div_dvd   = (cmd.div_sel == DIV_OWNER) ? prod_r : DW'(n);
  assign div_dvs   = (cmd.div_sel == DIV_OWNER) ? t1 : ID_BITS'(cnt_r);

  bipm_div #(.DW(DW), .VW(ID_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign pm1   = DW'(cnt_r) - DW'(1);
  assign guess = (div_quo > pm1) ? pm1 : div_quo;

  always_comb begin
    case (cmd.idx_op)
      IDX_CLR:   idx_nxt = '0;
      IDX_INC:   idx_nxt = idx_r + AW'(1);
      IDX_DEC:   idx_nxt = idx_r - AW'(1);
      IDX_GUESS: idx_nxt = AW'(guess);
      default:   idx_nxt = idx_r;
    endcase
  end

  assign incr = 64'(idx_r) < 64'(div_rem);
  assign d    = $signed({1'b0, t1}) - $signed({1'b0, t0});

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + ID_BITS'(div_quo) + ID_BITS'(incr);
    end
    if (cmd.best_ld && (!stat.idx_gt_0 || d > best_r)) begin
      best_r <= d;
    end
  end

  // results
  assign sum_l2g = g_r + t0;
  assign dif_cnt = t1 - t0;
  assign dif_own = g_r - t0;

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      res_st_r  <= cmd.res_st;
      res_own_r <= '0;
      case (cmd.res_sel)
        RES_L2G:  res_val_r <= ID_W'(sum_l2g);
        RES_CNT:  res_val_r <= ID_W'(dif_cnt);
        RES_OWN: begin
          res_val_r <= ID_W'(dif_own);
          res_own_r <= OWN_W'(idx_r);
        end
        RES_BEST: res_val_r <= ID_W'(best_r[ID_BITS-1:0]);
        default:  res_val_r <= '0;
      endcase
    end
    if (cmd.out_ld) begin
      out_val_r <= res_val_r;
      out_own_r <= res_own_r;
      out_st_r  <= res_st_r;
    end
  end

  assign out_result_value = out_val_r;
  assign out_owner_unit   = out_own_r;
  assign out_status       = out_st_r;

  always_comb begin
    stat.act        = act_r;
    stat.bad_p      = (cnt_r == '0) || (32'(cnt_r) > 32'(MAX_UNITS));
    stat.unsup      = (cnt_r > UNIT_W'(1)) && (64'(n) < 64'(cnt_r));
    stat.tv         = tv_r;
    stat.unit_gt_p  = unit_r > cnt_r;
    stat.unit_ge_p  = unit_r >= cnt_r;
    stat.g_ge_t1    = g_r >= t1;
    stat.g_lt_t0    = g_r < t0;
    stat.idx_lt_pm1 = (32'(idx_r) + 32'd1) < 32'(cnt_r);
    stat.idx_gt_0   = idx_r != '0;
    stat.idx_eq_p   = 32'(idx_r) == 32'(cnt_r);
    stat.div_busy   = div_busy;
  end
endmodule
`default_nettype wire

FILE: hw/rtl/bipm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bipm_ctrl
// Sequencer: decodes each request and steps the datapath through it.
// ----------------------------------------------------------------------------
module bipm_ctrl import bipm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  bipm_stat_t stat,
  output bipm_cmd_t  cmd
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_EV   = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_ODIV = 4'd5;
  localparam logic [3:0] S_WRD  = 4'd6;
  localparam logic [3:0] S_WEV  = 4'd7;
  localparam logic [3:0] S_BDIV = 4'd8;
  localparam logic [3:0] S_BLD  = 4'd9;
  localparam logic [3:0] S_LRD  = 4'd10;
  localparam logic [3:0] S_LEV  = 4'd11;
  localparam logic [3:0] S_LFIN = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  logic [3:0] state_r, state_nxt;
  logic [1:0] dir_r, dir_nxt;
  logic       ov_r, ov_nxt;
  logic       go_up, go_dn;

  assign go_up = (dir_r == DIR_UP) || (dir_r == DIR_NONE && stat.g_ge_t1);
  assign go_dn = (dir_r == DIR_DOWN) ||
                 (dir_r == DIR_NONE && !stat.g_ge_t1 && stat.g_lt_t0);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    dir_nxt   = dir_r;
    ov_nxt    = ov_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.act == ACT_UNUSED) begin
          cmd.res_ld = 1'b1;
          cmd.res_st = ST_RANGE;
          state_nxt  = S_DONE;
        end else if (stat.bad_p) begin
          cmd.res_ld = 1'b1;
          cmd.res_st = ST_UNSUP;
          state_nxt  = S_DONE;
        end else begin
          case (stat.act)
            ACT_BUILD: begin
              if (stat.unsup) begin
                cmd.tv_clr = 1'b1;
                cmd.res_ld = 1'b1;
                cmd.res_st = ST_UNSUP;
                state_nxt  = S_DONE;
              end else begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_BUILD;
                cmd.acc_clr   = 1'b1;
                cmd.idx_op    = IDX_CLR;
                state_nxt     = S_BDIV;
              end
            end
            ACT_TOP: begin
              cmd.wr_sel = WR_TOP;
              cmd.tv_set = 1'b1;
              cmd.res_ld = 1'b1;
              cmd.res_st = ST_OK;
              state_nxt  = S_DONE;
            end
            ACT_WRITE: begin
              cmd.res_ld = 1'b1;
              state_nxt  = S_DONE;
              if (stat.unit_gt_p) begin
                cmd.res_st = ST_RANGE;
              end else begin
                cmd.wr_sel = WR_UNIT;
                cmd.res_st = ST_OK;
              end
            end
            default: begin
              if (!stat.tv) begin
                cmd.res_ld = 1'b1;
                cmd.res_st = ST_UNSUP;
                state_nxt  = S_DONE;
              end else begin
                case (stat.act)
                  ACT_L2G, ACT_COUNT: begin
                    if (stat.unit_ge_p) begin
                      cmd.res_ld = 1'b1;
                      cmd.res_st = ST_RANGE;
                      state_nxt  = S_DONE;
                    end else begin
                      cmd.rd_sel = RA_UNIT;
                      state_nxt  = S_EV;
                    end
                  end
                  ACT_OWNER: begin
                    cmd.rd_sel = RA_CHK;
                    state_nxt  = S_CHK;
                  end
                  default: begin
                    cmd.idx_op = IDX_CLR;
                    state_nxt  = S_LRD;
                  end
                endcase
              end
            end
          endcase
        end
      end
      S_EV: begin
        cmd.res_ld  = 1'b1;
        cmd.res_sel = (stat.act == ACT_L2G) ? RES_L2G : RES_CNT;
        cmd.res_st  = ST_OK;
        state_nxt   = S_DONE;
      end
      S_CHK: begin
        if (stat.g_ge_t1 || stat.g_lt_t0) begin
          cmd.res_ld = 1'b1;
          cmd.res_st = ST_RANGE;
          state_nxt  = S_DONE;
        end else begin
          cmd.prod_ld = 1'b1;
          dir_nxt     = DIR_NONE;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_OWNER;
        state_nxt     = S_ODIV;
      end
      S_ODIV: begin
        if (!stat.div_busy) begin
          cmd.idx_op = IDX_GUESS;
          state_nxt  = S_WRD;
        end
      end
      S_WRD: begin
        cmd.rd_sel = RA_IDX;
        state_nxt  = S_WEV;
      end
      S_WEV: begin
        if (go_up && stat.idx_lt_pm1 && stat.g_ge_t1) begin
          dir_nxt    = DIR_UP;
          cmd.idx_op = IDX_INC;
          state_nxt  = S_WRD;
        end else if (go_dn && stat.idx_gt_0 && stat.g_lt_t0) begin
          dir_nxt    = DIR_DOWN;
          cmd.idx_op = IDX_DEC;
          state_nxt  = S_WRD;
        end else begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = RES_OWN;
          cmd.res_st  = ST_OK;
          state_nxt   = S_DONE;
        end
      end
      S_BDIV: begin
        if (!stat.div_busy) begin
          state_nxt = S_BLD;
        end
      end
      S_BLD: begin
        cmd.wr_sel  = WR_BUILD;
        cmd.acc_add = 1'b1;
        if (stat.idx_eq_p) begin
          cmd.tv_set = 1'b1;
          cmd.res_ld = 1'b1;
          cmd.res_st = ST_OK;
          state_nxt  = S_DONE;
        end else begin
          cmd.idx_op = IDX_INC;
        end
      end
      S_LRD: begin
        cmd.rd_sel = RA_IDX;
        state_nxt  = S_LEV;
      end
      S_LEV: begin
        cmd.best_ld = 1'b1;
        if (stat.idx_lt_pm1) begin
          cmd.idx_op = IDX_INC;
          state_nxt  = S_LRD;
        end else begin
          state_nxt = S_LFIN;
        end
      end
      S_LFIN: begin
        cmd.res_ld  = 1'b1;
        cmd.res_sel = RES_BEST;
        cmd.res_st  = ST_OK;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          cmd.out_ld = 1'b1;
          ov_nxt     = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dir_r   <= DIR_NONE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dir_r   <= dir_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = ov_r;
endmodule
`default_nettype wire

FILE: hw/rtl/block_index_partition_mapper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_index_partition_mapper
// Offset table that splits a global index range over processing units.
//
// Channels: in_ch takes one request (action, unit, id_value, offset_value),
// out_ch returns exactly one response per request, cfg_ch writes total_ids
// (index 0) and unit_count (index 1) and is always ready; write it only
// while no request is in flight.
// Steps: build runs the divider, then writes unit_count+1 table entries;
//   owner search runs the divider, then steps through the table; largest
//   share reads the table pair of each unit. Build and owner search share
//   one bit-serial divider; each owner or largest-share step reads one pair.
// One request is worked on at a time; the next is taken
// while the previous response still waits in the output register.
// Reset: table reads as zero, no valid table, total_ids 0, unit_count 1.
// A stalled receiver holds the response; the block finishes the next
// request and waits with it until the output register is free.
// ----------------------------------------------------------------------------
module block_index_partition_mapper import bipm_pkg::*; #(
  parameter int MAX_UNITS = DEF_MAX_UNITS,
  parameter int ID_BITS   = DEF_ID_BITS
) (
  input logic       clk,
  input logic       rst_n,
  bipm_cfg_if.sink  cfg_ch,
  bipm_req_if.sink  in_ch,
  bipm_rsp_if.source out_ch
);
  bipm_cmd_t  cmd;
  bipm_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  bipm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bipm_dp #(.MAX_UNITS(MAX_UNITS), .ID_BITS(ID_BITS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_valid        (cfg_ch.valid),
    .cfg_index        (cfg_ch.reg_index),
    .cfg_data         (cfg_ch.data),
    .in_action        (in_ch.action),
    .in_unit          (in_ch.unit),
    .in_id_value      (in_ch.id_value),
    .in_offset_value  (in_ch.offset_value),
    .out_result_value (out_ch.result_value),
    .out_owner_unit   (out_ch.owner_unit),
    .out_status       (out_ch.status)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request taken while another is in work");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_OK |->
      out_ch.result_value == '0 && out_ch.owner_unit == '0)
    else $error("error response carries data");

  a_no_write_on_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_sel != WR_NONE |-> cmd.rd_sel == RA_NONE)
    else $error("table read and write in one cycle");

  a_owner_single: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> stat.div_busy)
    else $error("divider did not start");
endmodule
`default_nettype wire
